>>> sv/mks_pkg.sv
package mks_pkg;

  // Register map, one 16-bit register per word
  localparam int unsigned CfgAddrW = 5;
  localparam logic [2:0] REG_TONE_FREQUENCY = 3'd0;
  localparam logic [2:0] REG_DOT_DURATION   = 3'd1;
  localparam logic [2:0] REG_DASH_DURATION  = 3'd2;
  localparam logic [2:0] REG_ELEMENT_GAP    = 3'd3;
  localparam logic [2:0] REG_WORD_GAP       = 3'd4;
  localparam logic [2:0] REG_CHAR_GAP       = 3'd5;

  typedef struct packed {
    logic [15:0] tone_frequency;
    logic [15:0] dot_duration;
    logic [15:0] dash_duration;
    logic [15:0] element_gap;
    logic [15:0] word_gap;
    logic [15:0] char_gap;
  } cfg_t;

  // Morse pattern, left-aligned: first element in bit 5, 1 = dash, 0 = dot
  typedef struct packed {
    logic       space;
    logic [2:0] len;
    logic [5:0] pat;
  } code_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TONE = 5'b00010,
    S_GAP  = 5'b00100,
    S_WORD = 5'b01000,
    S_CHAR = 5'b10000
  } seq_state_t;

  function automatic code_t code_lookup(input logic [7:0] c);
    code_t      r;
    logic [7:0] u;
    // fold lower case onto upper case
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    unique case (u)
      8'h41: r = '{space: 1'b0, len: 3'd2, pat: 6'b010000}; // A .-
      8'h42: r = '{space: 1'b0, len: 3'd4, pat: 6'b100000}; // B -...
      8'h43: r = '{space: 1'b0, len: 3'd4, pat: 6'b101000}; // C -.-.
      8'h44: r = '{space: 1'b0, len: 3'd3, pat: 6'b100000}; // D -..
      8'h45: r = '{space: 1'b0, len: 3'd1, pat: 6'b000000}; // E .
      8'h46: r = '{space: 1'b0, len: 3'd4, pat: 6'b001000}; // F ..-.
      8'h47: r = '{space: 1'b0, len: 3'd3, pat: 6'b110000}; // G --.
      8'h48: r = '{space: 1'b0, len: 3'd4, pat: 6'b000000}; // H ....
      8'h49: r = '{space: 1'b0, len: 3'd2, pat: 6'b000000}; // I ..
      8'h4A: r = '{space: 1'b0, len: 3'd4, pat: 6'b011100}; // J .---
      8'h4B: r = '{space: 1'b0, len: 3'd3, pat: 6'b101000}; // K -.-
      8'h4C: r = '{space: 1'b0, len: 3'd4, pat: 6'b010000}; // L .-..
      8'h4D: r = '{space: 1'b0, len: 3'd2, pat: 6'b110000}; // M --
      8'h4E: r = '{space: 1'b0, len: 3'd2, pat: 6'b100000}; // N -.
      8'h4F: r = '{space: 1'b0, len: 3'd3, pat: 6'b111000}; // O ---
      8'h50: r = '{space: 1'b0, len: 3'd4, pat: 6'b011000}; // P .--.
      8'h51: r = '{space: 1'b0, len: 3'd4, pat: 6'b110100}; // Q --.-
      8'h52: r = '{space: 1'b0, len: 3'd3, pat: 6'b010000}; // R .-.
      8'h53: r = '{space: 1'b0, len: 3'd3, pat: 6'b000000}; // S ...
      8'h54: r = '{space: 1'b0, len: 3'd1, pat: 6'b100000}; // T -
      8'h55: r = '{space: 1'b0, len: 3'd3, pat: 6'b001000}; // U ..-
      8'h56: r = '{space: 1'b0, len: 3'd4, pat: 6'b000100}; // V ...-
      8'h57: r = '{space: 1'b0, len: 3'd3, pat: 6'b011000}; // W .--
      8'h58: r = '{space: 1'b0, len: 3'd4, pat: 6'b100100}; // X -..-
      8'h59: r = '{space: 1'b0, len: 3'd4, pat: 6'b101100}; // Y -.--
      8'h5A: r = '{space: 1'b0, len: 3'd4, pat: 6'b110000}; // Z --..
      8'h30: r = '{space: 1'b0, len: 3'd5, pat: 6'b111110}; // 0 -----
      8'h31: r = '{space: 1'b0, len: 3'd5, pat: 6'b011110}; // 1 .----
      8'h32: r = '{space: 1'b0, len: 3'd5, pat: 6'b001110}; // 2 ..---
      8'h33: r = '{space: 1'b0, len: 3'd5, pat: 6'b000110}; // 3 ...--
      8'h34: r = '{space: 1'b0, len: 3'd5, pat: 6'b000010}; // 4 ....-
      8'h35: r = '{space: 1'b0, len: 3'd5, pat: 6'b000000}; // 5 .....
      8'h36: r = '{space: 1'b0, len: 3'd5, pat: 6'b100000}; // 6 -....
      8'h37: r = '{space: 1'b0, len: 3'd5, pat: 6'b110000}; // 7 --...
      8'h38: r = '{space: 1'b0, len: 3'd5, pat: 6'b111000}; // 8 ---..
      8'h39: r = '{space: 1'b0, len: 3'd5, pat: 6'b111100}; // 9 ----.
      8'h20: r = '{space: 1'b1, len: 3'd0, pat: 6'b000000}; // space
      8'h2E: r = '{space: 1'b0, len: 3'd6, pat: 6'b010101}; // . .-.-.-
      8'h2C: r = '{space: 1'b0, len: 3'd6, pat: 6'b110011}; // , --..--
      8'h5F: r = '{space: 1'b0, len: 3'd6, pat: 6'b001101}; // _ ..--.-
      8'h3A: r = '{space: 1'b0, len: 3'd6, pat: 6'b111000}; // : ---...
      8'h3B: r = '{space: 1'b0, len: 3'd6, pat: 6'b101010}; // ; -.-.-.
      8'h3F: r = '{space: 1'b0, len: 3'd6, pat: 6'b001100}; // ? ..--..
      8'h2F: r = '{space: 1'b0, len: 3'd5, pat: 6'b100100}; // / -..-.
      8'h28: r = '{space: 1'b0, len: 3'd5, pat: 6'b101100}; // ( -.--.
      8'h29: r = '{space: 1'b0, len: 3'd6, pat: 6'b101101}; // ) -.--.-
      8'h3D: r = '{space: 1'b0, len: 3'd5, pat: 6'b100010}; // = -...-
      8'h40: r = '{space: 1'b0, len: 3'd6, pat: 6'b011010}; // @ .--.-.
      default: r = '{space: 1'b0, len: 3'd0, pat: 6'b000000};
    endcase
    return r;
  endfunction

endpackage

>>> sv/mks_regs.sv
module mks_regs
  import mks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output cfg_t                cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;
  logic [15:0] rd_val;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[CfgAddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TONE_FREQUENCY: cfg_r.tone_frequency <= cfg_pwdata[15:0];
        REG_DOT_DURATION:   cfg_r.dot_duration   <= cfg_pwdata[15:0];
        REG_DASH_DURATION:  cfg_r.dash_duration  <= cfg_pwdata[15:0];
        REG_ELEMENT_GAP:    cfg_r.element_gap    <= cfg_pwdata[15:0];
        REG_WORD_GAP:       cfg_r.word_gap       <= cfg_pwdata[15:0];
        REG_CHAR_GAP:       cfg_r.char_gap       <= cfg_pwdata[15:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TONE_FREQUENCY: rd_val = cfg_r.tone_frequency;
      REG_DOT_DURATION:   rd_val = cfg_r.dot_duration;
      REG_DASH_DURATION:  rd_val = cfg_r.dash_duration;
      REG_ELEMENT_GAP:    rd_val = cfg_r.element_gap;
      REG_WORD_GAP:       rd_val = cfg_r.word_gap;
      REG_CHAR_GAP:       rd_val = cfg_r.char_gap;
      default:            rd_val = 16'd0;
    endcase
  end

  assign cfg_prdata = {16'd0, rd_val};
  assign cfg        = cfg_r;

endmodule

>>> sv/mks_seq.sv
module mks_seq
  import mks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  seq_state_t  state_r, state_nxt;
  logic [5:0]  pat_r, pat_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_tone_r;
  logic [15:0] out_freq_r;
  logic [15:0] out_dur_r;
  logic        out_last_r;
  logic        adv;
  logic        seg_tone;
  logic [15:0] seg_freq;
  logic [15:0] seg_dur;
  logic        seg_last;

  // advance one segment whenever the output slot is free or being drained
  assign adv       = (state_r != S_IDLE) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    code_t lk;
    lk        = code_lookup(in_tdata);
    state_nxt = state_r;
    pat_nxt   = pat_r;
    cnt_nxt   = cnt_r;
    seg_tone  = 1'b0;
    seg_freq  = 16'd0;
    seg_dur   = cfg.char_gap;
    seg_last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pat_nxt = lk.pat;
          cnt_nxt = lk.len;
          if (lk.space) begin
            state_nxt = S_WORD;
          end else if (lk.len != 3'd0) begin
            state_nxt = S_TONE;
          end else begin
            state_nxt = S_CHAR;
          end
        end
      end
      S_TONE: begin
        seg_tone = 1'b1;
        seg_freq = cfg.tone_frequency;
        seg_dur  = pat_r[5] ? cfg.dash_duration : cfg.dot_duration;
        if (adv) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        seg_dur = cfg.element_gap;
        if (adv) begin
          pat_nxt   = {pat_r[4:0], 1'b0};
          cnt_nxt   = cnt_r - 3'd1;
          state_nxt = (cnt_r == 3'd1) ? S_CHAR : S_TONE;
        end
      end
      S_WORD: begin
        seg_dur = cfg.word_gap;
        if (adv) begin
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        seg_dur  = cfg.char_gap;
        seg_last = 1'b1;
        if (adv) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
      pat_r       <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pat_r       <= pat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tone_r <= seg_tone;
      out_freq_r <= seg_freq;
      out_dur_r  <= seg_dur;
      out_last_r <= seg_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dur_r, out_freq_r};
  assign out_tuser  = out_tone_r;
  assign out_tlast  = out_last_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted request left sequencer idle");

  a_elem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TONE || state_r == S_GAP) |-> (cnt_r != 3'd0))
    else $error("element phase with empty element count");

  a_tone_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && state_r == S_TONE) |=> (state_r == S_GAP && out_tvalid && out_tuser))
    else $error("tone segment not followed by element gap");

  a_char_end: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && state_r == S_CHAR) |=> (state_r == S_IDLE && out_tvalid && out_tlast))
    else $error("character gap did not close the request");

endmodule

>>> sv/morse_keying_sequencer_unit.sv
// Morse keying sequencer. Each request on the in_ stream is one ASCII
// character; it expands into a run of tone/silence segments on the out_
// stream: a tone of dot or dash length plus an element gap per Morse element,
// a single word gap for a space, and a closing character gap flagged with
// out_tlast. Letters of either case, digits and eleven punctuation marks are
// known; any other code yields the character gap alone. The request is taken
// in the idle state, then the sequencer emits one segment per cycle while
// the output is not stalled. The element shift register shifts one Morse
// element per tone/gap pair. Results sit in an output register, so a new
// character is taken while the final segment of the previous one still waits.
// Program the six 16-bit timing registers over the cfg_ port while the unit
// is idle: 0x00 tone frequency, 0x04 dot, 0x08 dash, 0x0C element gap, 0x10
// word gap, 0x14 character gap; all reset to zero.
module morse_keying_sequencer_unit
  import mks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  // character requests
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] ascii_char
  // segments
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [15:0] frequency, [31:16] duration
  output logic                out_tuser,  // [0] tone_on
  output logic                out_tlast   // last_segment
);

  cfg_t cfg;

  // hold the timing registers
  mks_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // look up the code, shift out its elements and register each segment
  mks_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/morse_keying_sequencer_unit_tb.sv
module morse_keying_sequencer_unit_tb
  import mks_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Give up after this many cycles. The slowest correct run has up to 13 segments
  // per character, each behind a long stall.
  localparam int unsigned CycleLimit = 750000;
  localparam int unsigned RandomPerPhase = 41;
  // Register slots past the end of the map; a write there must change nothing
  localparam logic [2:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] frequency;
    logic [15:0] duration;
    logic        last_segment;
  } segment_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] ascii_char
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;  // [15:0] frequency, [31:16] duration
  logic                out_tuser;  // [0] tone_on
  logic                out_tlast;  // last_segment

  morse_keying_sequencer_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timing registers as the bench believes them to be
  cfg_t         keying_cfg;
  logic [7:0]   char_queue[$];          // characters waiting to be sent
  segment_t     expected_segments[$];   // segments predicted, not yet seen
  int unsigned  in_idle_pct;
  int unsigned  out_idle_pct;
  int unsigned  in_gap;
  int unsigned  out_stall;
  bit           request_taken;
  int unsigned  mismatch_count;
  int unsigned  chars_accepted;
  int unsigned  segments_checked;
  int unsigned  settings_used;
  int unsigned  cycle_count;
  segment_t     seen_seg;
  segment_t     want_seg;

  string letter_codes[26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_codes[10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };
  string known_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 .,_:;?/()=@";

  // Dots and dashes for one character; a lone blank for a space, empty if unknown
  function automatic string morse_pattern(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (u >= "A" && u <= "Z") return letter_codes[u - "A"];
    if (u >= "0" && u <= "9") return digit_codes[u - "0"];
    case (u)
      " ":     return " ";
      ".":     return ".-.-.-";
      ",":     return "--..--";
      "_":     return "..--.-";
      ":":     return "---...";
      ";":     return "-.-.-.";
      "?":     return "..--..";
      "/":     return "-..-.";
      "(":     return "-.--.";
      ")":     return "-.--.-";
      "=":     return "-...-";
      "@":     return ".--.-.";
      default: return "";
    endcase
  endfunction

  // Queue up the segments one character must produce
  function automatic void expand_char(input logic [7:0] c);
    string pat;
    int    n;
    pat = morse_pattern(c);
    n = 0;
    for (int i = 0; i < pat.len() && n < 12; i++) begin
      if (pat[i] == "-" || pat[i] == ".") begin
        expected_segments.push_back('{1'b1, keying_cfg.tone_frequency,
            (pat[i] == "-") ? keying_cfg.dash_duration : keying_cfg.dot_duration, 1'b0});
        expected_segments.push_back('{1'b0, 16'd0, keying_cfg.element_gap, 1'b0});
        n += 2;
      end else begin
        expected_segments.push_back('{1'b0, 16'd0, keying_cfg.word_gap, 1'b0});
        n++;
      end
    end
    expected_segments.push_back('{1'b0, 16'd0, keying_cfg.char_gap, 1'b1});
  endfunction

  // Mostly no pause; when pausing, mostly short, now and then long
  function automatic int unsigned pause_len(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Mostly table characters with random content, the rest any code at all
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return known_chars[$urandom_range(0, known_chars.len() - 1)];
  endfunction

  function automatic void report_field(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sender: present the next request at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!in_tvalid || request_taken) begin
      if (in_gap == 0) in_gap = pause_len(in_idle_pct);
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (char_queue.size() != 0) begin
        in_tdata  <= char_queue.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall out_tready at random
  always @(negedge clk) begin
    if (out_stall == 0) out_stall = pause_len(out_idle_pct);
    if (out_stall != 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted segment
  always @(posedge clk) begin
    request_taken = rst_n && in_tvalid && in_tready;
    if (request_taken) begin
      expand_char(in_tdata);
      chars_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen_seg = '{out_tuser, out_tdata[15:0], out_tdata[31:16], out_tlast};
      if (expected_segments.size() == 0) begin
        $display({"%0t ns: unexpected segment, expected none, ",
                  "got tone=%0d freq=%0d dur=%0d last=%0d"},
                 $time, seen_seg.tone_on, seen_seg.frequency, seen_seg.duration,
                 seen_seg.last_segment);
        mismatch_count++;
      end else begin
        want_seg = expected_segments.pop_front();
        report_field("tone_on", want_seg.tone_on, seen_seg.tone_on);
        report_field("frequency", want_seg.frequency, seen_seg.frequency);
        report_field("duration", want_seg.duration, seen_seg.duration);
        report_field("last_segment", want_seg.last_segment, seen_seg.last_segment);
        segments_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d segments still owed",
               cycle_count, expected_segments.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Write one register over the APB port, then read it back when it is mapped
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = {16'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_TONE_FREQUENCY: keying_cfg.tone_frequency = val;
      REG_DOT_DURATION:   keying_cfg.dot_duration   = val;
      REG_DASH_DURATION:  keying_cfg.dash_duration  = val;
      REG_ELEMENT_GAP:    keying_cfg.element_gap    = val;
      REG_WORD_GAP:       keying_cfg.word_gap       = val;
      REG_CHAR_GAP:       keying_cfg.char_gap       = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (idx <= REG_CHAR_GAP) begin
      @(negedge clk);
      cfg_psel = 1'b1;
      @(negedge clk);
      cfg_penable = 1'b1;
      do @(posedge clk); while (!cfg_pready);
      report_field("register readback", val, cfg_prdata[15:0]);
      @(negedge clk);
      cfg_psel    = 1'b0;
      cfg_penable = 1'b0;
    end
  endtask

  task automatic set_timing(input logic [15:0] freq, input logic [15:0] dot,
                            input logic [15:0] dash, input logic [15:0] elem,
                            input logic [15:0] word, input logic [15:0] chr);
    cfg_write(REG_TONE_FREQUENCY, freq);
    cfg_write(REG_DOT_DURATION, dot);
    cfg_write(REG_DASH_DURATION, dash);
    cfg_write(REG_ELEMENT_GAP, elem);
    cfg_write(REG_WORD_GAP, word);
    cfg_write(REG_CHAR_GAP, chr);
    settings_used++;
  endtask

  // Hold off until every queued request is taken and every segment has come out
  task automatic drain();
    do @(posedge clk);
    while (char_queue.size() != 0 || in_tvalid || expected_segments.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned in_pct, input int unsigned out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (RandomPerPhase) char_queue.push_back(pick_char());
    drain();
  endtask

  initial begin
    string directed;
    directed = "AzQm09.,_:;?/()=@ ";
    keying_cfg     = '0;
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    in_idle_pct    = 0;
    out_idle_pct   = 0;
    in_gap         = 0;
    out_stall      = 0;
    request_taken  = 1'b0;
    mismatch_count = 0;
    chars_accepted = 0;
    segments_checked = 0;
    settings_used  = 0;
    cycle_count    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: distinct timings so a swapped register shows up at once
    set_timing(16'd700, 16'd60, 16'd180, 16'd61, 16'd420, 16'd181);
    in_idle_pct  = 20;
    out_idle_pct = 20;
    for (int i = 0; i < directed.len(); i++) char_queue.push_back(directed[i]);
    // unknown codes: both ends of the byte, DEL, and the codes around the letter ranges
    char_queue.push_back(8'h00);
    char_queue.push_back(8'hFF);
    char_queue.push_back(8'h7F);
    char_queue.push_back(8'h60);
    char_queue.push_back(8'h5B);
    drain();

    // All registers at zero, no idling on either side
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(0, 0);

    // All registers at full scale
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(30, 30);

    // Random timings; then poke the unmapped slots, which must leave them alone
    set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    cfg_write(REG_UNMAPPED_6, 16'($urandom_range(0, 65535)));
    cfg_write(REG_UNMAPPED_7, 16'($urandom_range(0, 65535)));
    random_phase(50, 20);

    set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_phase(10, 60);

    // Alternating bit patterns across the registers
    set_timing(16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA);
    random_phase(25, 40);

    $display("covered %0d characters, %0d segments checked over %0d timing settings",
             chars_accepted, segments_checked, settings_used);
    $display("settings included all-zero, all-ones, random and alternating-bit timings");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
